// ===== hw/rtl/rcde_pkg.sv =====
// ----------------------------------------------------------------------------
// rcde_pkg
// shared constants, register indexes and the configuration struct of the
// radial capsule damage evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package rcde_pkg;

    localparam int NODE_INDEX_BITS_DEF = 16;
    localparam int COORD_BITS_DEF      = 21;

    localparam int CFG_W       = 63;
    localparam int CFG_IDX_W   = 3;
    localparam int RADIUS_W    = 21;
    localparam int DAMAGE_W    = 16;
    localparam int HEALTH_W    = 16;
    localparam int FRAC_BITS   = 16;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_A       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_B       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMAGE_AMOUNT = 3'd6;

    typedef struct packed {
        logic                shape_mode;
        logic                profile_mode;
        logic [CFG_W-1:0]    point_a;
        logic [CFG_W-1:0]    point_b;
        logic [RADIUS_W-1:0] min_radius;
        logic [RADIUS_W-1:0] max_radius;
        logic [DAMAGE_W-1:0] damage_amount;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/rcde_front.sv =====
// ----------------------------------------------------------------------------
// rcde_front
// accepts bond entries, drops those with unordered nodes or no health and
// hands the rest to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module rcde_front import rcde_pkg::*; #(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int NODE_INDEX_BITS = NODE_INDEX_BITS_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_valid,
    output logic                                               o_ready,
    input  wire logic signed [COORD_BITS-1:0]                  i_x,
    input  wire logic signed [COORD_BITS-1:0]                  i_y,
    input  wire logic signed [COORD_BITS-1:0]                  i_z,
    input  wire logic signed [HEALTH_W-1:0]                    i_health,
    input  wire logic [NODE_INDEX_BITS-1:0]                    i_na,
    input  wire logic [NODE_INDEX_BITS-1:0]                    i_nb,
    output logic                                               o_push,
    input  wire logic                                          i_full,
    output logic [3*COORD_BITS+2*NODE_INDEX_BITS-1:0]          o_item
) ;

    logic                                      r_valid;
    logic [3*COORD_BITS+2*NODE_INDEX_BITS-1:0] r_item;
    logic                                      keep;

    assign keep    = (i_na < i_nb) && (i_health > 0);
    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && keep;
            r_item  <= {i_nb, i_na, i_z, i_y, i_x};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rcde_fifo.sv =====
// ----------------------------------------------------------------------------
// rcde_fifo
// short queue between the classifying front and the arithmetic back end
// ----------------------------------------------------------------------------
`default_nettype none

module rcde_fifo import rcde_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rcde_back.sv =====
// ----------------------------------------------------------------------------
// rcde_back
// pipelined distance, projection divide, square root and damage profile
// ----------------------------------------------------------------------------
`default_nettype none

module rcde_back import rcde_pkg::*; #(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int NODE_INDEX_BITS = NODE_INDEX_BITS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire t_cfg                                     i_cfg,
    input  wire logic                                     i_valid,
    input  wire logic [3*COORD_BITS+2*NODE_INDEX_BITS-1:0] i_item,
    output logic                                          o_ready,
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output logic [NODE_INDEX_BITS-1:0]                    o_na,
    output logic [NODE_INDEX_BITS-1:0]                    o_nb,
    output logic [DAMAGE_W-1:0]                           o_dmg
);

    localparam int CB  = COORD_BITS;
    localparam int NIB = NODE_INDEX_BITS;
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 2;
    localparam int TW  = FRAC_BITS + 1;
    localparam int XW  = DW + TW + 1;
    localparam int K   = DW + 2;
    localparam int QW  = 2 * K;
    localparam int RW  = RADIUS_W;
    localparam int FW  = DAMAGE_W;
    localparam int NW  = FW + RW;
    localparam int CW  = ((K > RW) ? K : RW) + 1;
    localparam int GN  = 4 + FRAC_BITS;

    typedef enum logic [1:0] {SEL_W, SEL_U, SEL_P} t_sel;
    typedef enum logic [1:0] {PR_ZERO, PR_FULL, PR_DIV} t_prof;

    logic en;
    logic r_out_valid;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;

    // operand unpack
    logic signed [CB-1:0] pa [3];
    logic signed [CB-1:0] pb [3];
    logic signed [CB-1:0] pp [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa[i] = i_cfg.point_a[i*CB +: CB];
            pb[i] = i_cfg.point_b[i*CB +: CB];
            pp[i] = i_item[i*CB +: CB];
        end
    end

    // geometry carried from entry to the end of the t divide
    logic              r_g_valid [GN];
    logic signed [DW-1:0] r_g_v [GN][3];
    logic signed [DW-1:0] r_g_w [GN][3];
    logic signed [DW-1:0] r_g_u [GN][3];
    logic [NIB-1:0]    r_g_na [GN];
    logic [NIB-1:0]    r_g_nb [GN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid[0] <= 1'b0;
        end else if (en) begin
            r_g_valid[0] <= i_valid;
            for (int i = 0; i < 3; i++) begin
                r_g_v[0][i] <= DW'(pb[i]) - DW'(pa[i]);
                r_g_w[0][i] <= DW'(pp[i]) - DW'(pa[i]);
                r_g_u[0][i] <= DW'(pp[i]) - DW'(pb[i]);
            end
            r_g_na[0] <= i_item[3*CB +: NIB];
            r_g_nb[0] <= i_item[3*CB+NIB +: NIB];
        end
    end

    for (genvar g = 1; g < GN; g++) begin : g_geo
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_g_valid[g] <= 1'b0;
            end else if (en) begin
                r_g_valid[g] <= r_g_valid[g-1];
                r_g_v[g]     <= r_g_v[g-1];
                r_g_w[g]     <= r_g_w[g-1];
                r_g_u[g]     <= r_g_u[g-1];
                r_g_na[g]    <= r_g_na[g-1];
                r_g_nb[g]    <= r_g_nb[g-1];
            end
        end
    end

    // dot products
    logic signed [PW-1:0] r_b_vw [3];
    logic signed [PW-1:0] r_b_vv [3];
    logic signed [SW-1:0] r_c_c1;
    logic signed [SW-1:0] r_c_c2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_b_vw[i] <= r_g_v[0][i] * r_g_w[0][i];
                r_b_vv[i] <= r_g_v[0][i] * r_g_v[0][i];
            end
            r_c_c1 <= SW'(r_b_vw[0]) + SW'(r_b_vw[1]) + SW'(r_b_vw[2]);
            r_c_c2 <= SW'(r_b_vv[0]) + SW'(r_b_vv[1]) + SW'(r_b_vv[2]);
        end
    end

    // t = c1 * 2^16 / c2, one quotient bit per stage
    t_sel          r_sel [FRAC_BITS+1];
    logic [SW-1:0] r_rem [FRAC_BITS+1];
    logic [SW-1:0] r_c2  [FRAC_BITS+1];
    logic [TW-1:0] r_t   [FRAC_BITS+1];
    logic          use_w;
    logic          use_u;
    logic          q_int;

    assign use_w = !i_cfg.shape_mode || (r_c_c1 <= 0);
    assign use_u = !use_w && (r_c_c2 < r_c_c1);
    assign q_int = (r_c_c1 >= r_c_c2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sel[0] <= use_w ? SEL_W : (use_u ? SEL_U : SEL_P);
            r_rem[0] <= q_int ? SW'(r_c_c1 - r_c_c2) : SW'(r_c_c1);
            r_c2[0]  <= SW'(r_c_c2);
            r_t[0]   <= TW'(q_int);
        end
    end

    for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_tdiv
        logic [SW:0] r2;
        logic        ge;
        assign r2 = {r_rem[j-1], 1'b0};
        assign ge = (r2 >= {1'b0, r_c2[j-1]});
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sel[j] <= r_sel[j-1];
                r_c2[j]  <= r_c2[j-1];
                r_rem[j] <= ge ? SW'(r2 - {1'b0, r_c2[j-1]}) : SW'(r2);
                r_t[j]   <= {r_t[j-1][TW-2:0], ge};
            end
        end
    end

    // projection and offset vector
    logic                 r_e_valid;
    logic signed [XW-1:0] r_e_prod [3];
    logic signed [DW-1:0] r_e_w [3];
    logic signed [DW-1:0] r_e_u [3];
    t_sel                 r_e_sel;
    logic [NIB-1:0]       r_e_na;
    logic [NIB-1:0]       r_e_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= r_g_valid[GN-1];
            for (int i = 0; i < 3; i++) begin
                r_e_prod[i] <= r_g_v[GN-1][i] * $signed({1'b0, r_t[FRAC_BITS]});
                r_e_w[i]    <= r_g_w[GN-1][i];
                r_e_u[i]    <= r_g_u[GN-1][i];
            end
            r_e_sel <= r_sel[FRAC_BITS];
            r_e_na  <= r_g_na[GN-1];
            r_e_nb  <= r_g_nb[GN-1];
        end
    end

    logic signed [XW:0]  psum [3];
    logic signed [XW:0]  pdif [3];
    logic signed [K-1:0] dsel [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            psum[i] = (XW+1)'(r_e_prod[i]) + (XW+1)'(1 << (FRAC_BITS - 1));
            pdif[i] = (XW+1)'(r_e_w[i]) - (psum[i] >>> FRAC_BITS);
            unique case (r_e_sel)
                SEL_W:   dsel[i] = K'(r_e_w[i]);
                SEL_U:   dsel[i] = K'(r_e_u[i]);
                SEL_P:   dsel[i] = pdif[i][K-1:0];
                default: dsel[i] = K'(r_e_w[i]);
            endcase
        end
    end

    logic                r_f_valid;
    logic signed [K-1:0] r_f_d [3];
    logic [NIB-1:0]      r_f_na;
    logic [NIB-1:0]      r_f_nb;
    logic                r_h_valid;
    logic [QW-1:0]       r_h_sq [3];
    logic [NIB-1:0]      r_h_na;
    logic [NIB-1:0]      r_h_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_h_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
            r_f_d     <= dsel;
            r_f_na    <= r_e_na;
            r_f_nb    <= r_e_nb;
            r_h_valid <= r_f_valid;
            for (int i = 0; i < 3; i++) begin
                r_h_sq[i] <= r_f_d[i] * r_f_d[i];
            end
            r_h_na <= r_f_na;
            r_h_nb <= r_f_nb;
        end
    end

    // floor square root, one result bit per stage
    logic           r_s_valid [K+1];
    logic [QW-1:0]  r_s_n     [K+1];
    logic [K+1:0]   r_s_rem   [K+1];
    logic [K-1:0]   r_s_root  [K+1];
    logic [NIB-1:0] r_s_na    [K+1];
    logic [NIB-1:0] r_s_nb    [K+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid[0] <= 1'b0;
        end else if (en) begin
            r_s_valid[0] <= r_h_valid;
            r_s_n[0]     <= r_h_sq[0] + r_h_sq[1] + r_h_sq[2];
            r_s_rem[0]   <= '0;
            r_s_root[0]  <= '0;
            r_s_na[0]    <= r_h_na;
            r_s_nb[0]    <= r_h_nb;
        end
    end

    for (genvar k = 1; k <= K; k++) begin : g_sqrt
        logic [K+1:0] rem2;
        logic [K+1:0] trial;
        logic         ge;
        assign rem2  = {r_s_rem[k-1][K-1:0], r_s_n[k-1][QW-1 -: 2]};
        assign trial = {r_s_root[k-1], 2'b01};
        assign ge    = (rem2 >= trial);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_valid[k] <= 1'b0;
            end else if (en) begin
                r_s_valid[k] <= r_s_valid[k-1];
                r_s_n[k]     <= {r_s_n[k-1][QW-3:0], 2'b00};
                r_s_rem[k]   <= ge ? rem2 - trial : rem2;
                r_s_root[k]  <= {r_s_root[k-1][K-2:0], ge};
                r_s_na[k]    <= r_s_na[k-1];
                r_s_nb[k]    <= r_s_nb[k-1];
            end
        end
    end

    // damage profile
    logic [CW-1:0] dz;
    logic [CW-1:0] hz;
    logic [CW-1:0] lz;
    logic [CW-1:0] hdif;
    logic [RW-1:0] den;
    t_prof         prof;

    assign dz   = CW'(r_s_root[K]);
    assign hz   = CW'(i_cfg.max_radius);
    assign lz   = CW'(i_cfg.min_radius);
    assign hdif = hz - dz;
    assign den  = i_cfg.max_radius - i_cfg.min_radius;

    always_comb begin
        if (i_cfg.profile_mode) begin
            prof = (dz > hz || dz < lz) ? PR_ZERO : PR_FULL;
        end else if (dz > hz) begin
            prof = PR_ZERO;
        end else if (dz < lz || hz <= lz) begin
            prof = PR_FULL;
        end else begin
            prof = PR_DIV;
        end
    end

    logic           r_p_valid [FW+1];
    t_prof          r_p_code  [FW+1];
    logic [RW-1:0]  r_p_rem   [FW+1];
    logic [FW-1:0]  r_p_low   [FW+1];
    logic [FW-1:0]  r_p_q     [FW+1];
    logic [NIB-1:0] r_p_na    [FW+1];
    logic [NIB-1:0] r_p_nb    [FW+1];
    logic [NW-1:0]  num;

    assign num = NW'(i_cfg.damage_amount) * NW'(hdif[RW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid[0] <= 1'b0;
        end else if (en) begin
            r_p_valid[0] <= r_s_valid[K];
            r_p_code[0]  <= prof;
            r_p_rem[0]   <= num[NW-1:FW];
            r_p_low[0]   <= num[FW-1:0];
            r_p_q[0]     <= '0;
            r_p_na[0]    <= r_s_na[K];
            r_p_nb[0]    <= r_s_nb[K];
        end
    end

    for (genvar m = 1; m <= FW; m++) begin : g_pdiv
        logic [RW:0] r2;
        logic        ge;
        assign r2 = {r_p_rem[m-1], r_p_low[m-1][FW-1]};
        assign ge = (r2 >= {1'b0, den});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_p_valid[m] <= 1'b0;
            end else if (en) begin
                r_p_valid[m] <= r_p_valid[m-1];
                r_p_code[m]  <= r_p_code[m-1];
                r_p_rem[m]   <= ge ? RW'(r2 - {1'b0, den}) : RW'(r2);
                r_p_low[m]   <= {r_p_low[m-1][FW-2:0], 1'b0};
                r_p_q[m]     <= {r_p_q[m-1][FW-2:0], ge};
                r_p_na[m]    <= r_p_na[m-1];
                r_p_nb[m]    <= r_p_nb[m-1];
            end
        end
    end

    // output register
    logic [FW-1:0]  dmg;
    logic [NIB-1:0] r_out_na;
    logic [NIB-1:0] r_out_nb;
    logic [FW-1:0]  r_out_dmg;

    always_comb begin
        unique case (r_p_code[FW])
            PR_FULL: dmg = i_cfg.damage_amount;
            PR_DIV:  dmg = r_p_q[FW];
            default: dmg = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_p_valid[FW] && (dmg != '0);
            r_out_na    <= r_p_na[FW];
            r_out_nb    <= r_p_nb[FW];
            r_out_dmg   <= dmg;
        end
    end

    assign o_na  = r_out_na;
    assign o_nb  = r_out_nb;
    assign o_dmg = r_out_dmg;

endmodule

`default_nettype wire

// ===== hw/rtl/radial_capsule_damage_eval.sv =====
// ----------------------------------------------------------------------------
// radial_capsule_damage_eval
// radial falloff and cutter damage for bond entries, point or capsule shape
// ----------------------------------------------------------------------------
// slave stream takes one bond entry per transaction: centroid, health, nodes
// entries with node_a not below node_b or health not positive are dropped
// master stream gives one fracture command per damaged bond
// config port writes one register per cycle; the user must write it only
//   while the block is idle, the block itself does not enforce this
// throughput: one entry per cycle when not stalled, fully pipelined
// the back pipeline holds the 16-step t divider, the 24-step square root
//   and the 16-step falloff divider, one step per pipeline stage
// receiver stall freezes the back pipeline; the front and the
//   4-entry queue keep taking entries until the queue fills
// reset clears the configuration registers to zero and empties queue and pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module radial_capsule_damage_eval import rcde_pkg::*; #(
    parameter int NODE_INDEX_BITS = NODE_INDEX_BITS_DEF,
    parameter int COORD_BITS      = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // centroid_x, centroid_y, centroid_z, bond_health, node_a, node_b
    input  wire logic [((3*COORD_BITS+HEALTH_W+2*NODE_INDEX_BITS+7)/8)*8-1:0]
                                       i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // out_node_a, out_node_b, fracture_health
    output logic [((2*NODE_INDEX_BITS+DAMAGE_W+7)/8)*8-1:0] o_m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int NIB   = NODE_INDEX_BITS;
    localparam int ITEMW = 3 * CB + 2 * NIB;
    localparam int OUTW  = ((2 * NIB + DAMAGE_W + 7) / 8) * 8;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHAPE_MODE:    r_cfg.shape_mode    <= i_cfg_data[0];
                CFG_PROFILE_MODE:  r_cfg.profile_mode  <= i_cfg_data[0];
                CFG_POINT_A:       r_cfg.point_a       <= i_cfg_data;
                CFG_POINT_B:       r_cfg.point_b       <= i_cfg_data;
                CFG_MIN_RADIUS:    r_cfg.min_radius    <= i_cfg_data[RADIUS_W-1:0];
                CFG_MAX_RADIUS:    r_cfg.max_radius    <= i_cfg_data[RADIUS_W-1:0];
                CFG_DAMAGE_AMOUNT: r_cfg.damage_amount <= i_cfg_data[DAMAGE_W-1:0];
                default: ;
            endcase
        end
    end

    logic             push;
    logic             full;
    logic [ITEMW-1:0] front_item;
    logic             q_valid;
    logic [ITEMW-1:0] q_item;
    logic             back_ready;
    logic [NIB-1:0]   out_na;
    logic [NIB-1:0]   out_nb;
    logic [DAMAGE_W-1:0] out_dmg;

    rcde_front #(
        .COORD_BITS      (COORD_BITS),
        .NODE_INDEX_BITS (NODE_INDEX_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_x      (i_s_axis_tdata[0 +: CB]),
        .i_y      (i_s_axis_tdata[CB +: CB]),
        .i_z      (i_s_axis_tdata[2*CB +: CB]),
        .i_health (i_s_axis_tdata[3*CB +: HEALTH_W]),
        .i_na     (i_s_axis_tdata[3*CB+HEALTH_W +: NIB]),
        .i_nb     (i_s_axis_tdata[3*CB+HEALTH_W+NIB +: NIB]),
        .o_push   (push),
        .i_full   (full),
        .o_item   (front_item)
    );

    rcde_fifo #(
        .WIDTH (ITEMW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (back_ready),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    rcde_back #(
        .COORD_BITS      (COORD_BITS),
        .NODE_INDEX_BITS (NODE_INDEX_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_ready (back_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_na    (out_na),
        .o_nb    (out_nb),
        .o_dmg   (out_dmg)
    );

    assign o_m_axis_tdata = OUTW'({out_dmg, out_nb, out_na});

endmodule

`default_nettype wire

// ===== hw/rtl/rcde_checker.sv =====
// ----------------------------------------------------------------------------
// rcde_checker
// port level checks on the fracture command stream
// ----------------------------------------------------------------------------
`default_nettype none

module rcde_checker import rcde_pkg::*; #(
    parameter int NODE_INDEX_BITS = NODE_INDEX_BITS_DEF,
    parameter int COORD_BITS      = COORD_BITS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_m_axis_tvalid,
    input wire logic i_m_axis_tready,
    input wire logic [((2*NODE_INDEX_BITS+DAMAGE_W+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int NIB = NODE_INDEX_BITS;

    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result transaction right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_dmg_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[2*NIB +: DAMAGE_W] != '0)
        else $error("fracture with zero damage");

    a_node_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[0 +: NIB] < o_m_axis_tdata[NIB +: NIB])
        else $error("fracture for unordered node pair");

endmodule

bind radial_capsule_damage_eval rcde_checker #(
    .NODE_INDEX_BITS (NODE_INDEX_BITS),
    .COORD_BITS      (COORD_BITS)
) u_rcde_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_radial_capsule_damage_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_capsule_damage_eval
// checks fracture commands of the radial capsule damage evaluator against a
// local distance and profile predictor, under random stalls and several
// register settings, point and capsule shapes, falloff and cutter profiles
// ----------------------------------------------------------------------------

class fracture_scoreboard;
    logic [47:0] pending[$];
    int          errors;
    bit          shape_mode, profile_mode;
    logic [62:0] point_a, point_b;
    logic [20:0] min_radius, max_radius;
    logic [15:0] damage_amount;

    function new();
        errors = 0;
        shape_mode = 0; profile_mode = 0; point_a = 0; point_b = 0;
        min_radius = 0; max_radius = 0; damage_amount = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [62:0] val);
        case (idx)
            rcde_pkg::CFG_SHAPE_MODE:    shape_mode = val[0];
            rcde_pkg::CFG_PROFILE_MODE:  profile_mode = val[0];
            rcde_pkg::CFG_POINT_A:       point_a = val;
            rcde_pkg::CFG_POINT_B:       point_b = val;
            rcde_pkg::CFG_MIN_RADIUS:    min_radius = val[20:0];
            rcde_pkg::CFG_MAX_RADIUS:    max_radius = val[20:0];
            rcde_pkg::CFG_DAMAGE_AMOUNT: damage_amount = val[15:0];
            default: ;
        endcase
    endfunction

    function longint unsigned root(longint unsigned n);
        longint unsigned r, b;
        r = 0; b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function longint unsigned length3(longint d0, longint d1, longint d2);
        return root(d0 * d0 + d1 * d1 + d2 * d2);
    endfunction

    function longint coord(logic [62:0] pk, int i);
        logic signed [20:0] c;
        c = pk[i*21 +: 21];
        return longint'(c);
    endfunction

    function longint unsigned distance(longint p[3]);
        longint a[3], b[3], v[3], w[3], d[3], c1, c2, prod, proj;
        longint unsigned t;
        for (int i = 0; i < 3; i++) begin
            a[i] = coord(point_a, i); b[i] = coord(point_b, i);
        end
        if (!shape_mode) return length3(a[0]-p[0], a[1]-p[1], a[2]-p[2]);
        c1 = 0; c2 = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = b[i] - a[i]; w[i] = p[i] - a[i];
            c1 += v[i] * w[i]; c2 += v[i] * v[i];
        end
        if (c1 <= 0) return length3(w[0], w[1], w[2]);
        if (c2 < c1) return length3(p[0]-b[0], p[1]-b[1], p[2]-b[2]);
        t = (longint'(c1) << 16) / c2;
        for (int i = 0; i < 3; i++) begin
            prod = v[i] * longint'(t);
            proj = ((prod + 64'sd32768) >>> 16);
            d[i] = w[i] - proj;
        end
        return length3(d[0], d[1], d[2]);
    endfunction

    function void note_entry(logic [111:0] td);
        longint p[3];
        logic signed [15:0] health;
        logic [15:0] na, nb;
        longint unsigned dist_q, dmg, lo, hi, f;
        for (int i = 0; i < 3; i++) p[i] = coord(td[62:0], i);
        health = td[78:63]; na = td[94:79]; nb = td[110:95];
        if (na >= nb || health <= 0) return;
        dist_q = distance(p);
        lo = min_radius; hi = max_radius; f = damage_amount;
        if (profile_mode) dmg = (dist_q > hi || dist_q < lo) ? 0 : f;
        else if (dist_q > hi) dmg = 0;
        else if (dist_q < lo || hi <= lo) dmg = f;
        else dmg = (f * (hi - dist_q)) / (hi - lo);
        if (dmg != 0) pending.push_back({dmg[15:0], nb, na});
    endfunction

    function void check_fracture(logic [47:0] got);
        logic [47:0] exp_v;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_v = pending.pop_front();
        if (got[15:0] !== exp_v[15:0])
            $display("%0t: node_a exp %h got %h", $time, exp_v[15:0], got[15:0]);
        if (got[31:16] !== exp_v[31:16])
            $display("%0t: node_b exp %h got %h", $time, exp_v[31:16], got[31:16]);
        if (got[47:32] !== exp_v[47:32])
            $display("%0t: health exp %h got %h", $time, exp_v[47:32], got[47:32]);
        if (got !== exp_v) errors++;
    endfunction
endclass

module tb_radial_capsule_damage_eval;
    import rcde_pkg::*;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_s_axis_tvalid = 0;
    logic          o_s_axis_tready;
    logic [111:0]  i_s_axis_tdata = '0;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 0;
    logic [47:0]   o_m_axis_tdata;
    logic          i_cfg_we = 0;
    logic [2:0]    i_cfg_idx = '0;
    logic [62:0]   i_cfg_data = '0;

    int send_idle = 0, recv_idle = 0, hold_off = 0;
    fracture_scoreboard sb = new();

    always #10 i_clk = ~i_clk;

    radial_capsule_damage_eval DUT (.*);

    // receiver with random stalls and an optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_fracture(o_m_axis_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_axis_tready <= 0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [62:0] val);
        i_s_axis_tvalid <= 0;
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_entry(logic [111:0] td);
        while ($urandom_range(99) < send_idle) begin
            i_s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1; i_s_axis_tdata <= td;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_entry(td);
    endtask

    function automatic logic [20:0] rnd_coord(int spread);
        case ($urandom_range(5))
            0: return 21'h100000;
            1: return 21'h0FFFFF;
            2: return 21'($urandom);
            default: return 21'($signed($urandom_range(2*spread)) - spread);
        endcase
    endfunction

    function automatic logic [62:0] rnd_point(int spread);
        return {rnd_coord(spread), rnd_coord(spread), rnd_coord(spread)};
    endfunction

    function automatic logic [111:0] rnd_entry(int spread);
        logic [15:0] na, nb, h;
        na = 16'($urandom); nb = 16'($urandom);
        if ($urandom_range(9) < 8) begin
            if (na > nb) {na, nb} = {nb, na};
            if (na == nb) begin
                if (nb == 16'hFFFF) na = 0; else nb = nb + 1'b1;
            end
            h = 16'($urandom_range(32767, 1));
        end else begin
            h = 16'($urandom);
        end
        return {1'b0, nb, na, h, rnd_point(spread)};
    endfunction

    task automatic setup(int phase);
        int r0, r1;
        r0 = $urandom_range(3000); r1 = r0 + $urandom_range(4000);
        write_cfg(CFG_SHAPE_MODE, 63'(phase[0]));
        write_cfg(CFG_PROFILE_MODE, 63'(phase[1]));
        write_cfg(CFG_POINT_A, rnd_point(2000));
        write_cfg(CFG_POINT_B, rnd_point(2000));
        case (phase % 5)
            0: begin write_cfg(CFG_MIN_RADIUS, 63'(r0)); write_cfg(CFG_MAX_RADIUS, 63'(r1)); end
            1: begin write_cfg(CFG_MIN_RADIUS, 63'(r1)); write_cfg(CFG_MAX_RADIUS, 63'(r0)); end
            2: begin
                write_cfg(CFG_MIN_RADIUS, 63'd0); write_cfg(CFG_MAX_RADIUS, 63'h1FFFFF);
            end
            3: begin write_cfg(CFG_MIN_RADIUS, 63'(r0)); write_cfg(CFG_MAX_RADIUS, 63'(r0)); end
            default: begin
                write_cfg(CFG_MIN_RADIUS, 63'h1FFFFF); write_cfg(CFG_MAX_RADIUS, 63'h1FFFFF);
            end
        endcase
        write_cfg(CFG_DAMAGE_AMOUNT,
                  63'((phase % 4 == 3) ? 16'hFFFF : 16'($urandom_range(65535, 1))));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: wide falloff around origin, then capsule edge cases
        write_cfg(CFG_MAX_RADIUS, 63'h1FFFFF);
        write_cfg(CFG_DAMAGE_AMOUNT, 63'hFFFF);
        send_entry({1'b0, 16'd1, 16'd0, 16'h7FFF, 63'd0});
        send_entry({1'b0, 16'hFFFF, 16'hFFFE, 16'h0001, {3{21'h100000}}});
        send_entry({1'b0, 16'hFFFF, 16'hFFFE, 16'h0001, {3{21'h0FFFFF}}});
        send_entry({1'b0, 16'd5, 16'd5, 16'h0100, 63'd0});
        send_entry({1'b0, 16'd4, 16'd5, 16'h0100, 63'd0});
        send_entry({1'b0, 16'd6, 16'd5, 16'h0000, 63'd0});
        send_entry({1'b0, 16'd6, 16'd5, 16'h8000, 63'd0});
        drain();
        write_cfg(CFG_SHAPE_MODE, 63'd1);
        write_cfg(CFG_POINT_A, {21'd0, 21'd0, 21'd256});
        write_cfg(CFG_POINT_B, {21'd0, 21'd0, 21'd256});
        send_entry({1'b0, 16'd2, 16'd1, 16'h0100, {21'd0, 21'd300, 21'd0}});
        drain();
        write_cfg(CFG_POINT_B, {21'd0, 21'd0, 21'h1FFF00});
        for (int k = 0; k < 6; k++)
            send_entry({1'b0, 16'd9, 16'd3, 16'h0100, rnd_point(600)});
        drain();
        write_cfg(CFG_MIN_RADIUS, 63'd200);
        write_cfg(CFG_MAX_RADIUS, 63'd100);
        write_cfg(CFG_PROFILE_MODE, 63'd1);
        for (int k = 0; k < 4; k++)
            send_entry({1'b0, 16'd9, 16'd3, 16'h0100, rnd_point(600)});
        drain();
        for (int ph = 0; ph < 12; ph++) begin
            if (ph < 4) begin send_idle = 38; recv_idle = 79; end
            else if (ph < 8) begin send_idle = 79; recv_idle = 38; end
            else begin send_idle = 0; recv_idle = 0; end
            setup(ph);
            if (ph == 9) hold_off = 300;
            for (int k = 0; k < ((ph == 9) ? 100 : 30); k++)
                send_entry(rnd_entry((ph % 3 == 2) ? 1000000 : 4000));
            drain();
        end
        if (sb.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
